// ===== rtl/core/kfl_pkg.sv =====
// ============================================================================
// Keyframe LED fader package
// Request payload types, action codes, controller states and the command and
// status groups that join the controller to the datapath.
// ============================================================================
package kfl_pkg;

    // Action codes carried in the request.
    localparam logic [1:0] ACT_HDR   = 2'd0;
    localparam logic [1:0] ACT_COLOR = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    // Request payload, first field in the most significant bits.
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  frame_index;
        logic [31:0] frame_start;
        logic        fade;
        logic [4:0]  channel;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] query_time;
    } kfl_in_t;

    // Result payload.
    typedef struct packed {
        logic [4:0] out_channel;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic [7:0] found_frame;
        logic       last;
    } kfl_out_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_FRAC,
        ST_COL0,
        ST_COL1,
        ST_COL2,
        ST_MUL0,
        ST_MUL1,
        ST_DIVI,
        ST_DIV,
        ST_NEXTK,
        ST_OUT
    } kfl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic query_start;
        logic scan_en;
        logic hdr_rd0;
        logic hdr_rd1;
        logic hdr_rd2;
        logic frac;
        logic col_rd0;
        logic col_rd1;
        logic col_rd2;
        logic mul0;
        logic mul1;
        logic div_init;
        logic div_step;
        logic byte_store;
        logic chan_next;
    } kfl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_query;
        logic scan_done;
        logic fading;
        logic div_last;
        logic k_last;
        logic chan_last;
    } kfl_stat_t;

endpackage

// ===== rtl/core/kfl_ctrl.sv =====
// ============================================================================
// Keyframe LED fader controller
// Sequences the frame scan, header reads, per-channel color reads and the
// per-component blend division, and drives both handshakes.
// ============================================================================
module kfl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  kfl_pkg::kfl_stat_t stat,
    output kfl_pkg::kfl_cmd_t  cmd
);

    kfl_pkg::kfl_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kfl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kfl_pkg::ST_IDLE: begin
                if (s_valid && stat.in_query) state_next = kfl_pkg::ST_SCAN;
            end
            kfl_pkg::ST_SCAN: begin
                if (stat.scan_done) state_next = kfl_pkg::ST_HDR0;
            end
            kfl_pkg::ST_HDR0: state_next = kfl_pkg::ST_HDR1;
            kfl_pkg::ST_HDR1: state_next = kfl_pkg::ST_HDR2;
            kfl_pkg::ST_HDR2: state_next = kfl_pkg::ST_FRAC;
            kfl_pkg::ST_FRAC: state_next = kfl_pkg::ST_COL0;
            kfl_pkg::ST_COL0: state_next = kfl_pkg::ST_COL1;
            kfl_pkg::ST_COL1: state_next = kfl_pkg::ST_COL2;
            kfl_pkg::ST_COL2: begin
                state_next = stat.fading ? kfl_pkg::ST_MUL0 : kfl_pkg::ST_OUT;
            end
            kfl_pkg::ST_MUL0: state_next = kfl_pkg::ST_MUL1;
            kfl_pkg::ST_MUL1: state_next = kfl_pkg::ST_DIVI;
            kfl_pkg::ST_DIVI: state_next = kfl_pkg::ST_DIV;
            kfl_pkg::ST_DIV: begin
                if (stat.div_last) state_next = kfl_pkg::ST_NEXTK;
            end
            kfl_pkg::ST_NEXTK: begin
                state_next = stat.k_last ? kfl_pkg::ST_OUT : kfl_pkg::ST_MUL0;
            end
            kfl_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = stat.chan_last ? kfl_pkg::ST_IDLE : kfl_pkg::ST_COL0;
                end
            end
            default: state_next = kfl_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            kfl_pkg::ST_IDLE: begin
                s_ready         = 1'b1;
                cmd.accept      = s_valid;
                cmd.query_start = s_valid && stat.in_query;
            end
            kfl_pkg::ST_SCAN:  cmd.scan_en    = 1'b1;
            kfl_pkg::ST_HDR0:  cmd.hdr_rd0    = 1'b1;
            kfl_pkg::ST_HDR1:  cmd.hdr_rd1    = 1'b1;
            kfl_pkg::ST_HDR2:  cmd.hdr_rd2    = 1'b1;
            kfl_pkg::ST_FRAC:  cmd.frac       = 1'b1;
            kfl_pkg::ST_COL0:  cmd.col_rd0    = 1'b1;
            kfl_pkg::ST_COL1:  cmd.col_rd1    = 1'b1;
            kfl_pkg::ST_COL2:  cmd.col_rd2    = 1'b1;
            kfl_pkg::ST_MUL0:  cmd.mul0       = 1'b1;
            kfl_pkg::ST_MUL1:  cmd.mul1       = 1'b1;
            kfl_pkg::ST_DIVI:  cmd.div_init   = 1'b1;
            kfl_pkg::ST_DIV:   cmd.div_step   = 1'b1;
            kfl_pkg::ST_NEXTK: cmd.byte_store = 1'b1;
            kfl_pkg::ST_OUT: begin
                m_valid       = 1'b1;
                cmd.chan_next = m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/kfl_dp.sv =====
// ============================================================================
// Keyframe LED fader datapath
// Holds the frame tables and color store, scans for the selected frame,
// works out the fade fraction and blends each color component by a
// restoring division.
// ============================================================================
module kfl_dp #(
    parameter int MAX_FRAMES   = 256,
    parameter int NUM_CHANNELS = 26
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_wdata,
    input  kfl_pkg::kfl_in_t   s_data,
    output kfl_pkg::kfl_out_t  m_data,
    input  kfl_pkg::kfl_cmd_t  cmd,
    output kfl_pkg::kfl_stat_t stat
);

    localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW     = $clog2(MAX_FRAMES + 1);
    localparam int CA_W   = $clog2(MAX_FRAMES * NUM_CHANNELS);
    localparam int CHW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Storage.
    logic [31:0] start_mem [MAX_FRAMES];
    logic        fade_mem  [MAX_FRAMES];
    logic [31:0] col_mem   [MAX_FRAMES * NUM_CHANNELS];

    logic [8:0]        fc_reg;
    logic [31:0]       t_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     lim_reg;
    logic [CW-1:0]     scan_addr_reg;
    logic [CW-1:0]     idx_reg;
    logic              pend_reg;
    logic [CW-1:0]     f_reg;
    logic [31:0]       start_rd_reg;
    logic              fade_rd_reg;
    logic [31:0]       s0_reg, s1_reg;
    logic              fade0_reg;
    logic              fading_reg;
    logic [31:0]       num_reg, den_reg;
    logic [CA_W-1:0]   base0_reg, base1_reg;
    logic [31:0]       col_rd_reg;
    logic [31:0]       a_reg, b_reg;
    logic [39:0]       p0_reg, p1_reg;
    logic [41:0]       rem_reg, dsh_reg;
    logic [2:0]        div_cnt_reg;
    logic [7:0]        q_reg;
    logic [1:0]        k_reg;
    logic [CHW-1:0]    c_reg;
    logic [3:0][7:0]   out_bytes_reg;

    logic [31:0]       fc32;
    logic [CW-1:0]     cnt_eff;
    logic [CW-1:0]     f_plus1;
    logic [FIDX_W-1:0] st_raddr;
    logic [CA_W-1:0]   col_raddr;
    logic [CA_W-1:0]   col_waddr;
    logic              hdr_we, col_we;
    logic [7:0]        c0, c1;
    logic [41:0]       rem_sub;
    logic              ge;

    // Frame count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg <= '0;
        end else if (cfg_we) begin
            fc_reg <= cfg_wdata;
        end
    end

    // Effective frame count and index helpers.
    assign fc32    = 32'(fc_reg);
    assign cnt_eff = (fc32 > 32'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(fc32);
    assign f_plus1 = f_reg + CW'(1);

    // Write qualification for table loads.
    assign hdr_we = cmd.accept && (s_data.action == kfl_pkg::ACT_HDR)
                    && (32'(s_data.frame_index) < 32'(MAX_FRAMES));
    assign col_we = cmd.accept && (s_data.action == kfl_pkg::ACT_COLOR)
                    && (32'(s_data.frame_index) < 32'(MAX_FRAMES))
                    && (32'(s_data.channel) < 32'(NUM_CHANNELS));
    assign col_waddr = CA_W'(s_data.frame_index) * CA_W'(NUM_CHANNELS)
                       + CA_W'(s_data.channel);

    // Header table read address.
    always_comb begin
        priority if (cmd.scan_en) begin
            st_raddr = scan_addr_reg[FIDX_W-1:0];
        end else if (cmd.hdr_rd1) begin
            st_raddr = f_plus1[FIDX_W-1:0];
        end else begin
            st_raddr = f_reg[FIDX_W-1:0];
        end
    end

    // Header tables: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            start_mem[FIDX_W'(s_data.frame_index)] <= s_data.frame_start;
            fade_mem[FIDX_W'(s_data.frame_index)]  <= s_data.fade;
        end
        start_rd_reg <= start_mem[st_raddr];
        fade_rd_reg  <= fade_mem[st_raddr];
    end

    // Color store read address.
    assign col_raddr = (cmd.col_rd1 ? base1_reg : base0_reg) + CA_W'(c_reg);

    // Color store: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (col_we) begin
            col_mem[col_waddr] <= {s_data.alpha, s_data.blue, s_data.green, s_data.red};
        end
        col_rd_reg <= col_mem[col_raddr];
    end

    // Frame scan: one table entry issued per cycle, compared in the next cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_reg         <= '0;
            pend_reg      <= 1'b0;
            scan_addr_reg <= '0;
            lim_reg       <= '0;
        end else if (cmd.query_start) begin
            f_reg         <= '0;
            pend_reg      <= 1'b0;
            scan_addr_reg <= '0;
            lim_reg       <= ((cnt_eff == '0) || (s_data.query_time == '0)) ? '0 : cnt_eff;
        end else if (cmd.scan_en) begin
            if (pend_reg && (start_rd_reg <= t_reg)) begin
                f_reg <= idx_reg;
            end
            if (scan_addr_reg != lim_reg) begin
                pend_reg      <= 1'b1;
                idx_reg       <= scan_addr_reg;
                scan_addr_reg <= scan_addr_reg + CW'(1);
            end else begin
                pend_reg <= 1'b0;
            end
        end
    end

    // Query time and count capture.
    always_ff @(posedge aclk) begin
        if (cmd.query_start) begin
            t_reg   <= s_data.query_time;
            cnt_reg <= cnt_eff;
        end
    end

    // Header capture and fade fraction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fading_reg <= 1'b0;
        end else if (cmd.frac) begin
            fading_reg <= (cnt_reg != '0) && fade0_reg && (f_plus1 < cnt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hdr_rd1) begin
            s0_reg    <= start_rd_reg;
            fade0_reg <= fade_rd_reg;
        end
        if (cmd.hdr_rd2) begin
            s1_reg <= start_rd_reg;
        end
        if (cmd.frac) begin
            base0_reg <= CA_W'(f_reg) * CA_W'(NUM_CHANNELS);
            base1_reg <= CA_W'(f_reg) * CA_W'(NUM_CHANNELS) + CA_W'(NUM_CHANNELS);
            priority if ((t_reg < s0_reg) || (s1_reg <= s0_reg)) begin
                num_reg <= 32'd0;
                den_reg <= 32'd1;
            end else if (t_reg >= s1_reg) begin
                num_reg <= 32'd1;
                den_reg <= 32'd1;
            end else begin
                num_reg <= t_reg - s0_reg;
                den_reg <= s1_reg - s0_reg;
            end
        end
    end

    // Channel colors; an empty table reads as black.
    always_ff @(posedge aclk) begin
        if (cmd.col_rd1) begin
            a_reg <= (cnt_reg == '0) ? 32'd0 : col_rd_reg;
        end
        if (cmd.col_rd2) begin
            b_reg         <= fading_reg ? col_rd_reg : a_reg;
            out_bytes_reg <= a_reg;
        end else if (cmd.byte_store) begin
            out_bytes_reg[k_reg] <= q_reg;
        end
    end

    // Component and channel counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
            c_reg <= '0;
        end else if (cmd.query_start) begin
            k_reg <= '0;
            c_reg <= '0;
        end else if (cmd.chan_next) begin
            k_reg <= '0;
            c_reg <= c_reg + CHW'(1);
        end else if (cmd.byte_store) begin
            k_reg <= k_reg + 2'd1;
        end
    end

    // Blend products: c0 * (den - num) and c1 * num.
    assign c0 = a_reg[8*k_reg +: 8];
    assign c1 = b_reg[8*k_reg +: 8];

    always_ff @(posedge aclk) begin
        if (cmd.mul0) begin
            p0_reg <= 40'(c0) * 40'(den_reg - num_reg);
        end
        if (cmd.mul1) begin
            p1_reg <= 40'(c1) * 40'(num_reg);
        end
    end

    // Rounded quotient (2x + den) / (2 den), one bit per cycle, eight bits.
    assign rem_sub = rem_reg - dsh_reg;
    assign ge      = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_init) begin
            div_cnt_reg <= 3'd7;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= {1'b0, p0_reg + p1_reg, 1'b0} + 42'(den_reg);
            dsh_reg <= {2'b0, den_reg, 8'b0};
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            if (ge) begin
                rem_reg <= rem_sub;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[6:0], ge};
        end
    end

    // Status to the controller.
    assign stat.in_query  = (s_data.action == kfl_pkg::ACT_QUERY);
    assign stat.scan_done = (scan_addr_reg == lim_reg) && !pend_reg;
    assign stat.fading    = fading_reg;
    assign stat.div_last  = (div_cnt_reg == 3'd0);
    assign stat.k_last    = (k_reg == 2'd3);
    assign stat.chan_last = (c_reg == CHW'(NUM_CHANNELS - 1));

    // Result payload, held in registers while the request waits.
    assign m_data.out_channel = 5'(c_reg);
    assign m_data.out_red     = out_bytes_reg[0];
    assign m_data.out_green   = out_bytes_reg[1];
    assign m_data.out_blue    = out_bytes_reg[2];
    assign m_data.out_alpha   = out_bytes_reg[3];
    assign m_data.found_frame = 8'(f_reg);
    assign m_data.last        = stat.chan_last;

endmodule

// ===== rtl/core/keyframe_led_fader.sv =====
// Operation: a table write is stored as it is accepted. A query scans the frame
// table, reads its headers, then for each channel reads its colors and, on a
// fade frame, blends the four components with the 8-step divide.
// Throughput: one request at a time, set by the scan and the shared divider.
// Reset: synchronous active-low aresetn clears control state and frame_count;
// the tables hold nothing until written.
// ============================================================================
// Keyframe LED fader top level
// Keyframe LED show player: loads frame headers and channel colors and
// answers time queries with interpolated per-channel colors.
// ============================================================================
module keyframe_led_fader #(
    parameter int MAX_FRAMES   = 256,
    parameter int NUM_CHANNELS = 26
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [8:0]        cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  kfl_pkg::kfl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output kfl_pkg::kfl_out_t m_data
);

    kfl_pkg::kfl_cmd_t  cmd;
    kfl_pkg::kfl_stat_t stat;

    // Sequencer.
    kfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Tables and arithmetic.
    kfl_dp #(
        .MAX_FRAMES   (MAX_FRAMES),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== rtl/core/kfl_checker.sv =====
// ============================================================================
// Keyframe LED fader port checker
// Watches the top level's ports for handshake and sequencing errors.
// ============================================================================
module kfl_checker #(
    parameter int NUM_CHANNELS = 26
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input kfl_pkg::kfl_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input kfl_pkg::kfl_out_t m_data
);

    // A stalled result request keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result request changed while stalled");

    // The block never takes a new request while a result is on offer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // An accepted query blocks the input on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.action == kfl_pkg::ACT_QUERY) |=> !s_ready)
        else $error("input still ready after a query");

    // The final result of a query belongs to the highest channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> m_data.out_channel == 5'(NUM_CHANNELS - 1))
        else $error("last flag on the wrong channel");

endmodule

bind keyframe_led_fader kfl_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_kfl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
